/* design/kcl_pkg.sv */
`default_nettype none

package kcl_pkg;

  localparam int MAX_DIGITS_DEF = 8;
  localparam int RESULT_LIMIT   = 8;
  localparam int LEN_W          = 4;
  localparam int KEY_W          = 4;
  localparam int EV_W           = 4;

  localparam logic [KEY_W-1:0] KEY_0    = 4'd0;
  localparam logic [KEY_W-1:0] KEY_9    = 4'd9;
  localparam logic [KEY_W-1:0] KEY_A    = 4'd10;
  localparam logic [KEY_W-1:0] KEY_B    = 4'd11;
  localparam logic [KEY_W-1:0] KEY_C    = 4'd12;
  localparam logic [KEY_W-1:0] KEY_D    = 4'd13;
  localparam logic [KEY_W-1:0] KEY_STAR = 4'd14;
  localparam logic [KEY_W-1:0] KEY_HASH = 4'd15;

  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_VERIFY   = 2'd1;
  localparam logic [1:0] MODE_REGISTER = 2'd2;

  localparam logic [EV_W-1:0] EV_IGNORED    = 4'd0;
  localparam logic [EV_W-1:0] EV_ECHO       = 4'd1;
  localparam logic [EV_W-1:0] EV_ENTRY      = 4'd2;
  localparam logic [EV_W-1:0] EV_DIGIT      = 4'd3;
  localparam logic [EV_W-1:0] EV_CLEARED    = 4'd4;
  localparam logic [EV_W-1:0] EV_GRANTED    = 4'd5;
  localparam logic [EV_W-1:0] EV_DENIED     = 4'd6;
  localparam logic [EV_W-1:0] EV_LOCKED     = 4'd7;
  localparam logic [EV_W-1:0] EV_CANCEL     = 4'd8;
  localparam logic [EV_W-1:0] EV_REGISTERED = 4'd9;
  localparam logic [EV_W-1:0] EV_DELETED    = 4'd10;
  localparam logic [EV_W-1:0] EV_SHOWN      = 4'd11;
  localparam logic [EV_W-1:0] EV_LOGOUT     = 4'd12;
  localparam logic [EV_W-1:0] EV_DROPPED    = 4'd13;
  localparam logic [EV_W-1:0] EV_ENTRY_IGN  = 4'd14;

  localparam logic [LEN_W-1:0] SHOW_LAST_IDX = LEN_W'(RESULT_LIMIT - 1);

  typedef struct packed {
    logic            load_key;
    logic            mode_we;
    logic [1:0]      mode;
    logic            clr_entry_len;
    logic            entry_push;
    logic            clr_stored_len;
    logic            commit;
    logic            set_login;
    logic            clr_login;
    logic            inc_fail;
    logic            clr_fail;
    logic            idx_clr;
    logic            idx_inc;
    logic            out_load;
    logic [EV_W-1:0] out_ev;
    logic            out_last;
    logic            out_echo;
    logic            out_digit;
  } kcl_cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [1:0]       mode;
    logic             logged_in;
    logic             stored_empty;
    logic             entry_empty;
    logic             entry_full;
    logic             len_equal;
    logic             data_match;
    logic             idx_entry_end;
    logic             idx_show_end;
    logic             fail_reached;
    logic             out_free;
  } kcl_sts_t;

endpackage

`default_nettype wire

/* design/keypad_code_lock_core.sv */
// A single-result key passes through the decode and emit states before it reaches the output register.
// Verify '#': each compared digit takes a bank read state and a check state, then the result.
// Show 'C': each shown digit goes through a bank read state, then the output register, up to 8 digits.
// Next request is taken the cycle after the final result of the previous one is loaded,
// so a key is not taken before the last one is through; a full output register holds the controller.
// Reset: logged out, idle, no code stored, count 0, max_attempts 3; code banks need no clear.
`default_nettype none

module keypad_code_lock_core
  import kcl_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [KEY_W-1:0] key_i,
  input  wire logic             cfg_we_i,
  input  wire logic [3:0]       cfg_wdata_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [EV_W-1:0]       event_res_o,
  output logic [KEY_W-1:0]      echo_key_o,
  output logic [3:0]            code_digit_o,
  output logic [3:0]            fail_count_o,
  output logic                  is_logged_in_o,
  output logic                  last_o
);

  kcl_cmd_t cmd;
  kcl_sts_t sts;

  kcl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kcl_dp #(.MAX_DIGITS(MAX_DIGITS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_i          (key_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .event_res_o    (event_res_o),
    .echo_key_o     (echo_key_o),
    .code_digit_o   (code_digit_o),
    .fail_count_o   (fail_count_o),
    .is_logged_in_o (is_logged_in_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

/* design/kcl_ram.sv */
`default_nettype none

module kcl_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* design/kcl_dp.sv */
`default_nettype none

module kcl_dp
  import kcl_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [KEY_W-1:0] key_i,
  input  wire logic             cfg_we_i,
  input  wire logic [3:0]       cfg_wdata_i,
  input  wire kcl_cmd_t         cmd_i,
  output kcl_sts_t              sts_o,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output logic [EV_W-1:0]       event_res_o,
  output logic [KEY_W-1:0]      echo_key_o,
  output logic [3:0]            code_digit_o,
  output logic [3:0]            fail_count_o,
  output logic                  is_logged_in_o,
  output logic                  last_o
);

  localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(MAX_DIGITS);

  logic [KEY_W-1:0] key_q;
  logic [3:0]       max_att_q;
  logic             logged_in_q;
  logic [1:0]       mode_q;
  logic [LEN_W-1:0] stored_len_q;
  logic [LEN_W-1:0] entry_len_q;
  logic [3:0]       fail_q;
  logic [LEN_W-1:0] idx_q;
  logic             entry_bank_q;
  logic             out_valid_q;

  logic [3:0] rdata0, rdata1, stored_rd, entry_rd;
  logic       we0, we1;
  logic       out_free;

  // Two banks swap roles on a commit, so the new code needs no copy.
  assign we0 = cmd_i.entry_push && (entry_bank_q == 1'b0);
  assign we1 = cmd_i.entry_push && (entry_bank_q == 1'b1);
  assign entry_rd  = entry_bank_q ? rdata1 : rdata0;
  assign stored_rd = entry_bank_q ? rdata0 : rdata1;

  kcl_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (entry_len_q[AW-1:0]),
    .wdata_i (key_q),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata0)
  );

  kcl_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (entry_len_q[AW-1:0]),
    .wdata_i (key_q),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_att_q    <= 4'd3;
      logged_in_q  <= 1'b0;
      mode_q       <= MODE_IDLE;
      stored_len_q <= '0;
      entry_len_q  <= '0;
      fail_q       <= '0;
      idx_q        <= '0;
      entry_bank_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) max_att_q <= cfg_wdata_i;
      if (cmd_i.set_login) logged_in_q <= 1'b1;
      else if (cmd_i.clr_login) logged_in_q <= 1'b0;
      if (cmd_i.mode_we) mode_q <= cmd_i.mode;
      if (cmd_i.commit) begin
        stored_len_q <= entry_len_q;
        entry_bank_q <= ~entry_bank_q;
      end else if (cmd_i.clr_stored_len) begin
        stored_len_q <= '0;
      end
      if (cmd_i.clr_entry_len) entry_len_q <= '0;
      else if (cmd_i.entry_push) entry_len_q <= entry_len_q + 1'b1;
      if (cmd_i.inc_fail) fail_q <= fail_q + 1'b1;
      else if (cmd_i.clr_fail) fail_q <= '0;
      if (cmd_i.idx_clr) idx_q <= '0;
      else if (cmd_i.idx_inc) idx_q <= idx_q + 1'b1;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) key_q <= key_i;
    if (cmd_i.out_load) begin
      event_res_o    <= cmd_i.out_ev;
      echo_key_o     <= cmd_i.out_echo ? key_q : '0;
      code_digit_o   <= cmd_i.out_digit ? stored_rd : '0;
      fail_count_o   <= fail_q;
      is_logged_in_o <= logged_in_q;
      last_o         <= cmd_i.out_last;
    end
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o               = '0;
    sts_o.key           = key_q;
    sts_o.mode          = mode_q;
    sts_o.logged_in     = logged_in_q;
    sts_o.stored_empty  = (stored_len_q == '0);
    sts_o.entry_empty   = (entry_len_q == '0);
    sts_o.entry_full    = (entry_len_q == FULL_LEN);
    sts_o.len_equal     = (entry_len_q == stored_len_q);
    sts_o.data_match    = (entry_rd == stored_rd);
    sts_o.idx_entry_end = (idx_q == entry_len_q - 1'b1);
    sts_o.idx_show_end  = (idx_q == stored_len_q - 1'b1) || (idx_q == SHOW_LAST_IDX);
    sts_o.fail_reached  = (fail_q >= max_att_q);
    sts_o.out_free      = out_free;
  end

  a_entry_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_len_q <= FULL_LEN)
    else $error("entry length beyond capacity");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("result overwritten before it was taken");

  a_commit_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> (stored_len_q == $past(entry_len_q)) && (entry_bank_q != $past(entry_bank_q)))
    else $error("commit did not take entry length and swap banks");

endmodule

`default_nettype wire

/* design/kcl_ctrl.sv */
`default_nettype none

module kcl_ctrl
  import kcl_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire kcl_sts_t sts_i,
  output kcl_cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_EMIT     = 4'd2;
  localparam logic [3:0] S_CMP_RD   = 4'd3;
  localparam logic [3:0] S_CMP_CHK  = 4'd4;
  localparam logic [3:0] S_FAIL     = 4'd5;
  localparam logic [3:0] S_DENY     = 4'd6;
  localparam logic [3:0] S_LOCK     = 4'd7;
  localparam logic [3:0] S_SHOW_RD  = 4'd8;
  localparam logic [3:0] S_SHOW_OUT = 4'd9;

  logic [3:0]      state_q, state_d;
  logic [EV_W-1:0] ev_q, ev_d;
  logic            in_entry;

  assign in_entry   = (sts_i.mode == MODE_VERIFY) || (sts_i.mode == MODE_REGISTER);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    ev_d    = ev_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_key = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_EMIT;
        if (in_entry) begin
          case (sts_i.key) inside
            KEY_HASH: begin
              cmd_o.mode_we = 1'b1;
              cmd_o.mode    = MODE_IDLE;
              if (sts_i.mode == MODE_REGISTER) begin
                cmd_o.commit = 1'b1;
                ev_d         = EV_REGISTERED;
              end else if (!sts_i.len_equal) begin
                state_d = S_FAIL;
              end else if (sts_i.entry_empty) begin
                cmd_o.set_login = 1'b1;
                ev_d            = EV_GRANTED;
              end else begin
                cmd_o.idx_clr = 1'b1;
                state_d       = S_CMP_RD;
              end
            end
            KEY_STAR: begin
              cmd_o.clr_entry_len = 1'b1;
              ev_d                = EV_CLEARED;
            end
            [KEY_0:KEY_9]: begin
              if (sts_i.entry_full) begin
                ev_d = EV_DROPPED;
              end else begin
                cmd_o.entry_push = 1'b1;
                ev_d             = EV_DIGIT;
              end
            end
            default: ev_d = EV_ENTRY_IGN;
          endcase
        end else if (!sts_i.logged_in) begin
          case (sts_i.key)
            KEY_HASH: begin
              if (sts_i.stored_empty) begin
                cmd_o.set_login = 1'b1;
                ev_d            = EV_GRANTED;
              end else begin
                cmd_o.mode_we       = 1'b1;
                cmd_o.mode          = MODE_VERIFY;
                cmd_o.clr_entry_len = 1'b1;
                ev_d                = EV_ENTRY;
              end
            end
            KEY_STAR: ev_d = EV_CANCEL;
            default:  ev_d = EV_ECHO;
          endcase
        end else begin
          case (sts_i.key)
            KEY_A: begin
              cmd_o.mode_we       = 1'b1;
              cmd_o.mode          = MODE_REGISTER;
              cmd_o.clr_entry_len = 1'b1;
              ev_d                = EV_ENTRY;
            end
            KEY_B: begin
              cmd_o.clr_stored_len = 1'b1;
              ev_d                 = EV_DELETED;
            end
            KEY_C: begin
              // no code stored: the key causes no result
              if (sts_i.stored_empty) begin
                state_d = S_IDLE;
              end else begin
                cmd_o.idx_clr = 1'b1;
                state_d       = S_SHOW_RD;
              end
            end
            KEY_D: begin
              cmd_o.clr_login = 1'b1;
              ev_d            = EV_LOGOUT;
            end
            default: ev_d = EV_IGNORED;
          endcase
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_ev   = ev_q;
          cmd_o.out_last = 1'b1;
          cmd_o.out_echo = (ev_q == EV_ECHO);
          state_d        = S_IDLE;
        end
      end
      S_CMP_RD: state_d = S_CMP_CHK;
      S_CMP_CHK: begin
        if (!sts_i.data_match) begin
          state_d = S_FAIL;
        end else if (sts_i.idx_entry_end) begin
          cmd_o.set_login = 1'b1;
          ev_d            = EV_GRANTED;
          state_d         = S_EMIT;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_CMP_RD;
        end
      end
      S_FAIL: begin
        cmd_o.inc_fail = 1'b1;
        state_d        = S_DENY;
      end
      S_DENY: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_ev   = EV_DENIED;
          cmd_o.out_last = !sts_i.fail_reached;
          state_d        = sts_i.fail_reached ? S_LOCK : S_IDLE;
        end
      end
      S_LOCK: begin
        // report the count, then drop it in the same edge
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_ev   = EV_LOCKED;
          cmd_o.out_last = 1'b1;
          cmd_o.clr_fail = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_SHOW_RD: state_d = S_SHOW_OUT;
      S_SHOW_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_ev    = EV_SHOWN;
          cmd_o.out_digit = 1'b1;
          cmd_o.out_last  = sts_i.idx_show_end;
          if (sts_i.idx_show_end) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_SHOW_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q <= ev_d;
  end

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DECODE))
    else $error("accepted request not decoded");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && cmd_o.out_last) |=> (state_q == S_IDLE))
    else $error("final result did not return to idle");

  a_lock_after_deny: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOCK) |-> ($past(state_q) == S_DENY) || ($past(state_q) == S_LOCK))
    else $error("lockout without denial");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kcl_pkg::*;

  localparam int CODE_DIGITS = MAX_DIGITS_DEF;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 90;

  typedef struct packed {
    logic [EV_W-1:0]  ev;
    logic [KEY_W-1:0] echo;
    logic [3:0]       digit;
    logic [3:0]       fails;
    logic             logged_in;
    logic             last;
  } lock_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [KEY_W-1:0] key_i = '0;
  logic             cfg_we_i = 1'b0;
  logic [3:0]       cfg_wdata_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [EV_W-1:0]  event_res_o;
  logic [KEY_W-1:0] echo_key_o;
  logic [3:0]       code_digit_o;
  logic [3:0]       fail_count_o;
  logic             is_logged_in_o;
  logic             last_o;

  // lock state as the predictor sees it
  logic [3:0] lk_max;
  logic       lk_logged_in;
  logic [1:0] lk_mode;
  logic [3:0] lk_code [CODE_DIGITS];
  logic [3:0] lk_code_len;
  logic [3:0] lk_buf [CODE_DIGITS];
  logic [3:0] lk_buf_len;
  logic [3:0] lk_fails;

  lock_result_t lock_results_due[$];

  int   keys_sent = 0;
  int   results_seen = 0;
  int   result_errors = 0;
  int   lockouts_seen = 0;
  int   digits_shown = 0;
  int   settings_used = 0;
  int   burst_left = 0;
  bit   gaps_on = 1'b0;

  logic [7:0] rx_mask = 8'hFF;
  logic [2:0] rx_phase = '0;
  int         hold_reqs = 0;
  int         hold_seen = 0;
  int         hold_left = 0;

  keypad_code_lock_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .key_i          (key_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_res_o    (event_res_o),
    .echo_key_o     (echo_key_o),
    .code_digit_o   (code_digit_o),
    .fail_count_o   (fail_count_o),
    .is_logged_in_o (is_logged_in_o),
    .last_o         (last_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic void add_result(input logic [EV_W-1:0] ev, input logic [KEY_W-1:0] echo,
                                     input logic [3:0] digit);
    lock_results_due.push_back('{ev, echo, digit, lk_fails, lk_logged_in, 1'b0});
  endfunction

  function automatic void lock_step(input logic [KEY_W-1:0] k);
    int   n_before;
    logic code_ok;
    n_before = lock_results_due.size();
    if (lk_mode == MODE_VERIFY || lk_mode == MODE_REGISTER) begin
      if (k == KEY_HASH) begin
        if (lk_mode == MODE_REGISTER) begin
          lk_code = lk_buf;
          lk_code_len = lk_buf_len;
          lk_mode = MODE_IDLE;
          add_result(EV_REGISTERED, '0, '0);
        end else begin
          lk_mode = MODE_IDLE;
          code_ok = (lk_buf_len == lk_code_len);
          for (int i = 0; i < CODE_DIGITS; i++)
            if (i < lk_buf_len && lk_buf[i] != lk_code[i]) code_ok = 1'b0;
          if (code_ok) begin
            lk_logged_in = 1'b1;
            add_result(EV_GRANTED, '0, '0);
          end else begin
            lk_fails = lk_fails + 4'd1;
            add_result(EV_DENIED, '0, '0);
            // lockout reports the count, then drops it
            if (lk_fails >= lk_max) begin
              add_result(EV_LOCKED, '0, '0);
              lk_fails = '0;
            end
          end
        end
      end else if (k == KEY_STAR) begin
        lk_buf_len = '0;
        add_result(EV_CLEARED, '0, '0);
      end else if (k <= KEY_9) begin
        if (lk_buf_len < CODE_DIGITS) begin
          lk_buf[lk_buf_len] = k;
          lk_buf_len = lk_buf_len + 4'd1;
          add_result(EV_DIGIT, '0, '0);
        end else begin
          add_result(EV_DROPPED, '0, '0);
        end
      end else begin
        add_result(EV_ENTRY_IGN, '0, '0);
      end
    end else if (!lk_logged_in) begin
      if (k == KEY_HASH) begin
        if (lk_code_len == 0) begin
          lk_logged_in = 1'b1;
          add_result(EV_GRANTED, '0, '0);
        end else begin
          lk_mode = MODE_VERIFY;
          lk_buf_len = '0;
          add_result(EV_ENTRY, '0, '0);
        end
      end else if (k == KEY_STAR) begin
        add_result(EV_CANCEL, '0, '0);
      end else begin
        add_result(EV_ECHO, k, '0);
      end
    end else begin
      if (k == KEY_A) begin
        lk_mode = MODE_REGISTER;
        lk_buf_len = '0;
        add_result(EV_ENTRY, '0, '0);
      end else if (k == KEY_B) begin
        lk_code_len = '0;
        add_result(EV_DELETED, '0, '0);
      end else if (k == KEY_C) begin
        for (int i = 0; i < CODE_DIGITS && i < RESULT_LIMIT; i++)
          if (i < lk_code_len) add_result(EV_SHOWN, '0, lk_code[i]);
      end else if (k == KEY_D) begin
        lk_logged_in = 1'b0;
        add_result(EV_LOGOUT, '0, '0);
      end else begin
        add_result(EV_IGNORED, '0, '0);
      end
    end
    if (lock_results_due.size() > n_before)
      lock_results_due[lock_results_due.size()-1].last = 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [3:0] want,
                                      input logic [3:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      result_errors++;
    end
  endfunction

  // receiver: repeating ready pattern, or a long hold-off when requested
  always @(posedge clk_i) begin
    rx_phase <= rx_phase + 3'd1;
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_OFF_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rx_mask[rx_phase];
    end
  end

  always @(posedge clk_i) begin : result_check
    lock_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (lock_results_due.size() == 0) begin
        $display("%0t ns: result with nothing expected, expected none, got event %0d",
                 $time, event_res_o);
        result_errors++;
      end else begin
        want = lock_results_due.pop_front();
        results_seen++;
        if (want.ev == EV_LOCKED) lockouts_seen++;
        if (want.ev == EV_SHOWN) digits_shown++;
        check_field("event_res", want.ev, event_res_o);
        check_field("echo_key", want.echo, echo_key_o);
        check_field("code_digit", want.digit, code_digit_o);
        check_field("fail_count", want.fails, fail_count_o);
        check_field("is_logged_in", 4'(want.logged_in), 4'(is_logged_in_o));
        check_field("last", 4'(want.last), 4'(last_o));
      end
    end
  end

  // send one key request; valid stays high afterwards unless a gap follows
  task automatic send_key(input logic [KEY_W-1:0] k);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 20 : 4)) @(posedge clk_i);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    key_i <= k;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    lock_step(k);
    keys_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (lock_results_due.size() != 0) @(posedge clk_i);
    // a key with no result may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_max_attempts(input logic [3:0] value);
    drain_results();
    cfg_wdata_i <= value;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    lk_max = value;
    settings_used++;
    cfg_we_i <= 1'b0;
  endtask

  function automatic int pick_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 10);
    if ($urandom_range(0, 9) == 0) return 0;
    return $urandom_range(1, 4);
  endfunction

  task automatic type_digits(input int count);
    for (int i = 0; i < count; i++) send_key(KEY_W'($urandom_range(0, 9)));
  endtask

  // mostly well-formed sessions driven by the current lock state, some noise
  task automatic random_session();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      send_key(KEY_W'($urandom_range(0, 15)));
    end else if (lk_mode != MODE_IDLE) begin
      type_digits($urandom_range(0, 3));
      send_key(KEY_HASH);
    end else if (!lk_logged_in) begin
      if (lk_code_len == 0) begin
        send_key(KEY_HASH);
      end else begin
        send_key(KEY_HASH);
        if (r < 70) begin
          if ($urandom_range(0, 5) == 0) begin
            type_digits(2);
            send_key(KEY_STAR);
          end
          for (int i = 0; i < lk_code_len; i++) send_key(lk_code[i]);
        end else begin
          type_digits(pick_length());
          if (r > 90) send_key(KEY_W'($urandom_range(KEY_A, KEY_D)));
        end
        send_key(KEY_HASH);
      end
    end else begin
      if (r < 45) begin
        send_key(KEY_A);
        type_digits(pick_length());
        send_key(KEY_HASH);
      end else if (r < 60) begin
        send_key(KEY_C);
      end else if (r < 68) begin
        send_key(KEY_B);
      end else if (r < 95) begin
        send_key(KEY_D);
      end else begin
        send_key(($urandom_range(0, 1) == 0) ? KEY_STAR : KEY_W'($urandom_range(0, 9)));
      end
    end
  endtask

  task automatic test_logged_out_keys();
    send_key(KEY_0);
    send_key(KEY_STAR);
  endtask

  task automatic test_open_access();
    send_key(KEY_HASH);
    send_key(KEY_C);
    send_key(KEY_9);
    send_key(KEY_B);
  endtask

  task automatic test_empty_registration();
    send_key(KEY_A);
    send_key(KEY_HASH);
  endtask

  task automatic test_full_entry();
    send_key(KEY_A);
    send_key(KEY_D);
    send_key(KEY_STAR);
    // ninth digit overflows the buffer
    for (int i = 0; i < 9; i++) send_key((i == 0) ? KEY_9 : KEY_W'(i - 1));
    send_key(KEY_HASH);
    send_key(KEY_C);
  endtask

  task automatic test_zero_limit_lockout();
    send_key(KEY_D);
    set_max_attempts(4'd0);
    send_key(KEY_HASH);
    send_key(KEY_HASH);
  endtask

  task automatic test_random_phase(input logic [3:0] limit, input int n_keys,
                                   input bit gaps, input logic [7:0] ready_mask);
    int start;
    set_max_attempts(limit);
    gaps_on = gaps;
    rx_mask <= ready_mask;
    start = keys_sent;
    while (keys_sent - start < n_keys) random_session();
  endtask

  task automatic test_output_stall();
    int start;
    drain_results();
    rx_mask <= 8'hFF;
    hold_reqs <= hold_reqs + 1;
    gaps_on = 1'b0;
    start = keys_sent;
    while (keys_sent - start < 25) random_session();
  endtask

  initial begin
    lk_max = 4'd3;
    lk_logged_in = 1'b0;
    lk_mode = MODE_IDLE;
    lk_code_len = '0;
    lk_buf_len = '0;
    lk_fails = '0;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      lk_code[i] = '0;
      lk_buf[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_logged_out_keys();
    test_open_access();
    test_empty_registration();
    test_full_entry();
    test_zero_limit_lockout();

    test_random_phase(4'd1, 45, 1'b1, 8'hFF);
    test_random_phase(4'd15, 45, 1'b0, 8'b1011_0110);
    test_random_phase(4'd3, 45, 1'b1, 8'($urandom) | 8'h01);
    test_random_phase(4'd0, 35, 1'b1, 8'b0101_0101);
    test_output_stall();
    test_random_phase(4'($urandom_range(1, 14)), 45, 1'b1, 8'($urandom) | 8'h01);
    test_random_phase(4'd2, 45, 1'b0, 8'hFF);

    drain_results();
    $display("Sent %0d keys and checked %0d results under %0d attempt-limit settings,",
             keys_sent, results_seen, settings_used);
    $display("with %0d lockouts and %0d code digits shown.", lockouts_seen, digits_shown);
    if (result_errors == 0 && lock_results_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timeout: %0d results still expected", lock_results_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
